@@ design/framebuffer_shape_drawer_unit_defines.svh @@
// Assertion macros shared by the drawing engine.
`ifndef FRAMEBUFFER_SHAPE_DRAWER_UNIT_DEFINES_SVH
`define FRAMEBUFFER_SHAPE_DRAWER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/fsd_pkg.sv @@
package fsd_pkg;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_LINE  = 3'd2,
    OP_RECT  = 3'd3,
    OP_CIRC  = 3'd4
  } op_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  localparam int CoordBits = 8;
  localparam int SizeBits  = 9;

endpackage

@@ design/framebuffer_shape_drawer_unit.sv @@
// After reset the frame store is cleared, one pixel a cycle, over all MAX_WIDTH*MAX_HEIGHT
// pixels before the first request is taken. A rectangle is scanned row by row, a line runs
// the serial divider and then steps along x, a circle scans its clipped box; one store write
// port sets the pace.
// A result waits in the output register while the next request is accepted.
// Reset is synchronous and active high; the frame size registers return to 256, clamped to MAX_WIDTH/MAX_HEIGHT.
module framebuffer_shape_drawer_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int COLOR_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  fsd_pkg::reg_index_t       cfg_index,
  input  logic [fsd_pkg::SizeBits-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                op,
  input  logic [7:0]                x0,
  input  logic [7:0]                y0,
  input  logic [7:0]                x1,
  input  logic [7:0]                y1,
  input  logic [7:0]                radius,
  input  logic [7:0]                red,
  input  logic [7:0]                green,
  input  logic [7:0]                blue,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                read_red,
  output logic [7:0]                read_green,
  output logic [7:0]                read_blue,
  output logic                      status
);
  import fsd_pkg::*;
  `include "framebuffer_shape_drawer_unit_defines.svh"

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PW = 3 * COLOR_BITS;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_READ  = 9'b000000100,
    S_RECT  = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_LINE  = 9'b000100000,
    S_CSET  = 9'b001000000,
    S_CSQ   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  function automatic logic [AW-1:0] pix_addr(input logic [8:0] px, input logic [8:0] py);
    return AW'(32'(py) * 32'(MAX_WIDTH) + 32'(px));
  endfunction

  function automatic logic [8:0] clamp_w(input logic [8:0] v, input int maxv);
    logic [8:0] r;
    if (v == 9'd0) r = 9'd1;
    else if (32'(v) > maxv) r = 9'(maxv);
    else r = v;
    return r;
  endfunction

  state_t state;
  logic   circ_scan;
  logic [8:0] fw, fh;
  logic [7:0] c_x0, c_y0, c_r;
  logic [PW-1:0] pen;
  logic drop;
  logic [7:0] res_r, res_g, res_b;
  logic [8:0] sx, sy, scan_xlo, scan_xhi, scan_yhi;
  logic [2:0] div_cnt;
  logic [7:0] div_rem, div_q;
  logic [7:0] l_dx, l_j, l_r;
  logic [8:0] l_q;
  logic       l_neg;
  logic [1:0] sq_cnt;
  logic [15:0] r2, dx2, dx20, dy2;
  logic signed [9:0] ddx, ddx0, ddy;
  logic [AW-1:0] clr_addr;
  logic [PW-1:0] rd_q;
  logic [PW-1:0] mem [Depth];

  logic [8:0] pix_x, pix_y;
  logic pix_try, in_range, circ_in;
  logic mem_we;
  logic [AW-1:0] mem_waddr, rd_addr;
  logic [PW-1:0] mem_wdata;
  logic accept, out_free;
  logic [7:0] dy_mag;
  logic [8:0] div_t, r_sum;
  logic div_ge;
  logic signed [9:0] xlo, ylo;
  logic [8:0] xhi, yhi, xlo_c, ylo_c, xhi_c, yhi_c, fw_m1, fh_m1;
  logic drop_c, empty_c;
  logic signed [9:0] sq_a;
  logic [7:0] sq_abs;
  logic [15:0] sq;
  logic signed [17:0] dx2_inc, dy2_inc;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    pix_x   = sx;
    pix_y   = sy;
    pix_try = 1'b0;
    unique case (state)
      S_RECT: pix_try = 1'b1;
      S_LINE: begin
        pix_x   = {1'b0, c_x0} + {1'b0, l_j};
        pix_y   = l_neg ? ({1'b0, c_y0} - l_q) : ({1'b0, c_y0} + l_q);
        pix_try = 1'b1;
      end
      S_CSQ: pix_try = circ_scan && circ_in;
      default: pix_try = 1'b0;
    endcase
  end

  assign in_range  = (pix_x < fw) && (pix_y < fh);
  assign circ_in   = ({1'b0, dx2} + {1'b0, dy2}) <= {1'b0, r2};
  assign mem_we    = (state == S_CLEAR) || (pix_try && in_range);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : pix_addr(pix_x, pix_y);
  assign mem_wdata = (state == S_CLEAR) ? '0 : pen;
  assign rd_addr   = pix_addr({1'b0, x0}, {1'b0, y0});

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[rd_addr];
  end

  assign dy_mag = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
  assign div_t  = {div_rem, div_q[7]};
  assign div_ge = div_t >= {1'b0, l_dx};
  assign r_sum  = {1'b0, l_r} + {1'b0, div_rem};

  assign xlo     = $signed({2'b00, c_x0}) - $signed({2'b00, c_r});
  assign ylo     = $signed({2'b00, c_y0}) - $signed({2'b00, c_r});
  assign xhi     = {1'b0, c_x0} + {1'b0, c_r};
  assign yhi     = {1'b0, c_y0} + {1'b0, c_r};
  assign fw_m1   = fw - 9'd1;
  assign fh_m1   = fh - 9'd1;
  assign xlo_c   = xlo[9] ? 9'd0 : xlo[8:0];
  assign ylo_c   = ylo[9] ? 9'd0 : ylo[8:0];
  assign xhi_c   = (xhi > fw_m1) ? fw_m1 : xhi;
  assign yhi_c   = (yhi > fh_m1) ? fh_m1 : yhi;
  assign drop_c  = xlo[9] || ylo[9] || (xhi >= fw) || (yhi >= fh);
  assign empty_c = (xlo_c > xhi_c) || (ylo_c > yhi_c);

  always_comb begin
    unique case (sq_cnt)
      2'd0:    sq_a = $signed({2'b00, c_r});
      2'd1:    sq_a = $signed({1'b0, scan_xlo}) - $signed({2'b00, c_x0});
      default: sq_a = $signed({1'b0, sy}) - $signed({2'b00, c_y0});
    endcase
  end

  assign sq_abs  = sq_a[9] ? 8'(-sq_a) : sq_a[7:0];
  assign sq      = sq_abs * sq_abs;
  assign dx2_inc = $signed({2'b00, dx2}) + $signed({{7{ddx[9]}}, ddx, 1'b1});
  assign dy2_inc = $signed({2'b00, dy2}) + $signed({{7{ddy[9]}}, ddy, 1'b1});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      circ_scan <= 1'b0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      fw        <= clamp_w(9'd256, MAX_WIDTH);
      fh        <= clamp_w(9'd256, MAX_HEIGHT);
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  fw <= clamp_w(cfg_data, MAX_WIDTH);
          REG_FRAME_HEIGHT: fh <= clamp_w(cfg_data, MAX_HEIGHT);
        endcase
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(Depth - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_r <= '0;
            res_g <= '0;
            res_b <= '0;
            drop  <= 1'b0;
            pen   <= {COLOR_BITS'(red), COLOR_BITS'(green), COLOR_BITS'(blue)};
            c_x0  <= x0;
            c_y0  <= y0;
            c_r   <= radius;
            circ_scan <= 1'b0;
            case (op)
              OP_READ: begin
                drop  <= !(({1'b0, x0} < fw) && ({1'b0, y0} < fh));
                state <= S_READ;
              end
              OP_WRITE: begin
                sx <= {1'b0, x0};
                sy <= {1'b0, y0};
                scan_xlo <= {1'b0, x0};
                scan_xhi <= {1'b0, x0};
                scan_yhi <= {1'b0, y0};
                state <= S_RECT;
              end
              OP_LINE: begin
                if (x1 > x0) begin
                  l_dx    <= x1 - x0;
                  l_neg   <= y1 < y0;
                  div_q   <= dy_mag;
                  div_rem <= '0;
                  div_cnt <= '0;
                  state   <= S_DIV;
                end else if (x1 == x0 && y1 > y0) begin
                  sx <= {1'b0, x0};
                  sy <= {1'b0, y0};
                  scan_xlo <= {1'b0, x0};
                  scan_xhi <= {1'b0, x0};
                  scan_yhi <= {1'b0, y1} - 9'd1;
                  state <= S_RECT;
                end else begin
                  state <= S_DONE;
                end
              end
              OP_RECT: begin
                if (x1 > x0 && y1 > y0) begin
                  sx <= {1'b0, x0};
                  sy <= {1'b0, y0};
                  scan_xlo <= {1'b0, x0};
                  scan_xhi <= {1'b0, x1} - 9'd1;
                  scan_yhi <= {1'b0, y1} - 9'd1;
                  state <= S_RECT;
                end else begin
                  state <= S_DONE;
                end
              end
              OP_CIRC: state <= S_CSET;
              default: state <= S_DONE;
            endcase
          end
        end
        S_READ: begin
          if (!drop) begin
            res_r <= 8'(rd_q[3*COLOR_BITS-1:2*COLOR_BITS]);
            res_g <= 8'(rd_q[2*COLOR_BITS-1:COLOR_BITS]);
            res_b <= 8'(rd_q[COLOR_BITS-1:0]);
          end
          state <= S_DONE;
        end
        S_RECT: begin
          drop <= drop || !in_range;
          if (sx == scan_xhi) begin
            sx <= scan_xlo;
            if (sy == scan_yhi) state <= S_DONE;
            else sy <= sy + 9'd1;
          end else begin
            sx <= sx + 9'd1;
          end
        end
        S_DIV: begin
          div_rem <= div_ge ? 8'(div_t - {1'b0, l_dx}) : div_t[7:0];
          div_q   <= {div_q[6:0], div_ge};
          div_cnt <= div_cnt + 3'd1;
          if (div_cnt == 3'd7) begin
            l_j   <= '0;
            l_q   <= '0;
            l_r   <= '0;
            state <= S_LINE;
          end
        end
        S_LINE: begin
          drop <= drop || !in_range;
          if (r_sum >= {1'b0, l_dx}) begin
            l_r <= 8'(r_sum - {1'b0, l_dx});
            l_q <= l_q + {1'b0, div_q} + 9'd1;
          end else begin
            l_r <= r_sum[7:0];
            l_q <= l_q + {1'b0, div_q};
          end
          l_j <= l_j + 8'd1;
          if (l_j == l_dx - 8'd1) state <= S_DONE;
        end
        S_CSET: begin
          drop     <= drop_c;
          sx       <= xlo_c;
          sy       <= ylo_c;
          scan_xlo <= xlo_c;
          scan_xhi <= xhi_c;
          scan_yhi <= yhi_c;
          sq_cnt   <= '0;
          state    <= empty_c ? S_DONE : S_CSQ;
        end
        S_CSQ: begin
          if (!circ_scan) begin
            sq_cnt <= sq_cnt + 2'd1;
            unique case (sq_cnt)
              2'd0: r2 <= sq;
              2'd1: begin
                dx20 <= sq;
                dx2  <= sq;
                ddx0 <= sq_a;
                ddx  <= sq_a;
              end
              default: begin
                dy2 <= sq;
                ddy <= sq_a;
                circ_scan <= 1'b1;
              end
            endcase
          end else if (sx == scan_xhi) begin
            sx  <= scan_xlo;
            ddx <= ddx0;
            dx2 <= dx20;
            if (sy == scan_yhi) begin
              state <= S_DONE;
            end else begin
              sy  <= sy + 9'd1;
              ddy <= ddy + 10'sd1;
              dy2 <= dy2_inc[15:0];
            end
          end else begin
            sx  <= sx + 9'd1;
            ddx <= ddx + 10'sd1;
            dx2 <= dx2_inc[15:0];
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            read_red   <= res_r;
            read_green <= res_g;
            read_blue  <= res_b;
            status     <= drop;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FSD_ASSERT_IMP(a_no_accept_in_clear, state == S_CLEAR, in_stall)
  `FSD_ASSERT_NXT(a_accept_leaves_idle, accept, state != S_IDLE)
  `FSD_ASSERT_IMP(a_write_only_when_drawing, mem_we,
    state == S_CLEAR || state == S_RECT || state == S_LINE || (state == S_CSQ && circ_scan))

endmodule

@@ test/fsd_checker.sv @@
module fsd_checker
  import fsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  reg_index_t          cfg_index,
  input  logic [SizeBits-1:0] cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [2:0]          op,
  input  logic [7:0]          x0,
  input  logic [7:0]          y0,
  input  logic [7:0]          x1,
  input  logic [7:0]          y1,
  input  logic [7:0]          radius,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [7:0]          read_red,
  input  logic [7:0]          read_green,
  input  logic [7:0]          read_blue,
  input  logic                status,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] rd;
    logic [7:0] gr;
    logic [7:0] bl;
    logic       st;
  } pixel_result_t;

  logic [23:0]   frame [0:65535];
  int            width_now;
  int            height_now;
  logic [23:0]   pen;
  logic          dropped;
  pixel_result_t results_due[$];

  function automatic int clamp_size(logic [SizeBits-1:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  function automatic void plot(int x, int y);
    if (x < 0 || y < 0 || x >= width_now || y >= height_now) begin
      dropped = 1'b1;
      return;
    end
    frame[y * 256 + x] = pen;
  endfunction

  function automatic void draw_line(int xa, int ya, int xb, int yb);
    int dx;
    int dy;
    dx = xb - xa;
    dy = yb - ya;
    if (xb > xa) begin
      for (int j = 0; j < dx; j++) plot(xa + j, ya + (dy * j) / dx);
    end else if (xb == xa) begin
      for (int j = 0; j < dy; j++) plot(xa, ya + j);
    end
  endfunction

  function automatic void fill_circle(int cx, int cy, int r);
    int xlo;
    int xhi;
    int ylo;
    int yhi;
    xlo = cx - r;
    xhi = cx + r;
    ylo = cy - r;
    yhi = cy + r;
    if (xlo < 0 || ylo < 0 || xhi >= width_now || yhi >= height_now) dropped = 1'b1;
    if (xlo < 0) xlo = 0;
    if (ylo < 0) ylo = 0;
    if (xhi > width_now - 1) xhi = width_now - 1;
    if (yhi > height_now - 1) yhi = height_now - 1;
    for (int y = ylo; y <= yhi; y++) begin
      for (int x = xlo; x <= xhi; x++) begin
        if ((x - cx) * (x - cx) + (y - cy) * (y - cy) <= r * r) frame[y * 256 + x] = pen;
      end
    end
  endfunction

  function automatic pixel_result_t run_command();
    pixel_result_t res;
    res = '0;
    pen = {red, green, blue};
    dropped = 1'b0;
    case (op)
      OP_READ: begin
        if (x0 < width_now && y0 < height_now) begin
          {res.rd, res.gr, res.bl} = frame[y0 * 256 + x0];
        end else begin
          dropped = 1'b1;
        end
      end
      OP_WRITE: plot(x0, y0);
      OP_LINE:  draw_line(x0, y0, x1, y1);
      OP_RECT: begin
        for (int row = y0; row < y1; row++) draw_line(x0, row, x1, row);
      end
      OP_CIRC:  fill_circle(x0, y0, radius);
      default: ;
    endcase
    res.st = dropped;
    return res;
  endfunction

  initial begin
    for (int i = 0; i < 65536; i++) frame[i] = '0;
    width_now = 256;
    height_now = 256;
    errors = 0;
  end

  assign pending = results_due.size();

  always @(posedge clk) begin
    pixel_result_t want;
    pixel_result_t got;
    if (rst) begin
      width_now <= 256;
      height_now <= 256;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{read_red, read_green, read_blue, status};
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (in_valid && !in_stall) results_due.push_back(run_command());
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_now <= clamp_size(cfg_data);
          REG_FRAME_HEIGHT: height_now <= clamp_size(cfg_data);
          default: ;
        endcase
      end
    end
  end
endmodule

@@ test/tb_framebuffer_shape_drawer_unit.sv @@
module tb_framebuffer_shape_drawer_unit;
  import fsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  reg_index_t          cfg_index = REG_FRAME_WIDTH;
  logic [SizeBits-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [2:0]          op = '0;
  logic [7:0]          x0 = '0, y0 = '0, x1 = '0, y1 = '0, radius = '0;
  logic [7:0]          red = '0, green = '0, blue = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          read_red, read_green, read_blue;
  logic                status;
  int                  errors;
  int                  pending;
  int                  idle_cycles = 0;
  int                  burst_left = 0;
  int                  width_now = 256;
  int                  height_now = 256;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  framebuffer_shape_drawer_unit u_dut (.*);
  fsd_checker u_check (.*);

  always @(posedge clk) begin
    int mode;
    mode = ($time / 4000) % 3;
    case (mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 300000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send(input logic [2:0] o, input int a, input int b, input int c,
                      input int d, input int r, input logic [23:0] color);
    op <= o;
    x0 <= a[7:0];
    y0 <= b[7:0];
    x1 <= c[7:0];
    y1 <= d[7:0];
    radius <= r[7:0];
    {red, green, blue} <= color;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic set_size(input int w, input int h);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= w[SizeBits-1:0];
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= h[SizeBits-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    width_now = (w % 512 == 0) ? 1 : ((w % 512 > 256) ? 256 : w % 512);
    height_now = (h % 512 == 0) ? 1 : ((h % 512 > 256) ? 256 : h % 512);
  endtask

  function automatic int near_coord(int lim);
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, (lim + 2 > 255) ? 255 : lim + 2);
  endfunction

  task automatic random_item();
    int kind;
    int a;
    int b;
    int c;
    int d;
    int r;
    logic [2:0] o;
    kind = $urandom_range(0, 99);
    a = near_coord(width_now);
    b = near_coord(height_now);
    c = a + $urandom_range(0, 12) - 2;
    d = b + $urandom_range(0, 12) - 2;
    r = $urandom_range(0, 8);
    if (kind < 25) o = OP_READ;
    else if (kind < 50) o = OP_WRITE;
    else if (kind < 68) begin
      o = OP_LINE;
      c = a + $urandom_range(0, 60) - 4;
      d = b + $urandom_range(0, 80) - 40;
    end else if (kind < 82) o = OP_RECT;
    else if (kind < 96) o = OP_CIRC;
    else o = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 199) == 0) begin
      c = $urandom_range(0, 255);
      d = $urandom_range(0, 255);
      r = $urandom_range(0, 255);
    end
    if (c < 0) c = 0;
    if (c > 255) c = 255;
    if (d < 0) d = 0;
    if (d > 255) d = 255;
    if ($urandom_range(0, 9) == 0) r = $urandom_range(0, 255) % 40;
    send(o, a, b, c, d, r, 24'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send(OP_READ, 0, 0, 0, 0, 0, 24'hffffff);
    send(OP_WRITE, 255, 255, 0, 0, 0, 24'hffffff);
    send(OP_READ, 255, 255, 0, 0, 0, 24'h0);
    send(OP_WRITE, 0, 0, 0, 0, 0, 24'h123456);
    send(OP_READ, 0, 0, 0, 0, 0, 24'h0);
    send(OP_LINE, 10, 40, 30, 20, 0, 24'hff0000);
    send(OP_LINE, 50, 10, 50, 25, 0, 24'h00ff00);
    send(OP_LINE, 60, 10, 40, 30, 0, 24'h0000ff);
    send(OP_LINE, 70, 30, 70, 20, 0, 24'h0000ff);
    send(OP_LINE, 0, 0, 255, 255, 0, 24'haaaaaa);
    send(OP_RECT, 5, 5, 9, 8, 0, 24'h555555);
    send(OP_RECT, 9, 8, 5, 5, 0, 24'h555555);
    send(OP_RECT, 250, 250, 255, 255, 0, 24'h0f0f0f);
    send(OP_CIRC, 100, 100, 0, 0, 0, 24'hf0f0f0);
    send(OP_CIRC, 3, 3, 0, 0, 6, 24'h808080);
    send(OP_CIRC, 128, 128, 0, 0, 255, 24'h010203);
    send(OP_READ, 7, 6, 0, 0, 0, 24'h0);
    send(3'd5, 1, 2, 3, 4, 5, 24'hffffff);
    send(3'd7, 255, 255, 255, 255, 255, 24'hffffff);

    set_size(20, 10);
    send(OP_WRITE, 20, 3, 0, 0, 0, 24'hffffff);
    send(OP_READ, 3, 10, 0, 0, 0, 24'h0);
    send(OP_RECT, 15, 5, 25, 12, 0, 24'h222222);
    send(OP_LINE, 0, 9, 30, 0, 0, 24'h333333);
    set_size(0, 0);
    send(OP_WRITE, 0, 0, 0, 0, 0, 24'h444444);
    send(OP_READ, 1, 0, 0, 0, 0, 24'h0);
    set_size(511, 511);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        1: set_size(1, 256);
        2: set_size(256, 1);
        3: set_size(37, 200);
        4: set_size($urandom_range(257, 511), $urandom_range(1, 64));
        5: set_size($urandom_range(1, 256), $urandom_range(1, 256));
        6: set_size(256, 256);
        default: ;
      endcase
      repeat (125) random_item();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
